// ===== design/swaabb_pkg.sv =====
// Shared types and constants for the swept box contact-time pipeline.
// No dependencies.
package swaabb_pkg;

    localparam int COORD_W         = 24;
    localparam int DIFF_W          = COORD_W + 1;   // signed corner difference / velocity
    localparam int NUM_W           = COORD_W + 1;   // unsigned magnitude
    localparam int REM_W           = NUM_W + 1;
    localparam int Q_W             = 16;
    localparam int T_W             = 17;            // time with saturation headroom
    localparam int LANES           = 4;
    localparam int DIV_STAGES_DEF  = 8;

    localparam logic [T_W-1:0] TIME_ONE = 17'd32768;
    localparam logic [T_W-1:0] TIME_SAT = 17'h1FFFF;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_min_x;
        logic signed [COORD_W-1:0] a_min_y;
        logic signed [COORD_W-1:0] a_max_x;
        logic signed [COORD_W-1:0] a_max_y;
        logic signed [COORD_W-1:0] b_min_x;
        logic signed [COORD_W-1:0] b_min_y;
        logic signed [COORD_W-1:0] b_max_x;
        logic signed [COORD_W-1:0] b_max_y;
        logic signed [COORD_W-1:0] va_x;
        logic signed [COORD_W-1:0] va_y;
        logic signed [COORD_W-1:0] vb_x;
        logic signed [COORD_W-1:0] vb_y;
    } box_pair_t;

    typedef struct packed {
        logic            hit;
        logic [Q_W-1:0]  t_first;
        logic [Q_W-1:0]  t_last;
    } contact_t;

endpackage

// ===== design/swaabb_stream_if.sv =====
// Valid/ready stream channel carrying one payload per beat.
// Payload type is a parameter; used with types from swaabb_pkg.
interface swaabb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/swept_aabb_collision_time.sv =====
// Swept 2-D box contact test: pipelined slab test with four restoring dividers.
// Depends on swaabb_pkg and swaabb_stream_if.
//
// Usage:
//   boxes  (sink)   : one beat per box pair, corners and per-frame displacements, Q15.8.
//   result (source) : one beat per pair: hit, t_first, t_last (Q1.15, 32768 = 1.0).
// A pair passes the input register, stage B, stage C, the DIV_STAGES divider
// stages and the output register in order (default 8, two quotient bits per stage).
// Throughput is one pair per cycle except during receiver stalls; the four dividers
// (entry/exit time per axis) are fully pipelined, so pipeline depth sets latency only.
// Reset (rst_n low, asynchronous) clears every valid bit; no beat is in flight
// afterwards and boxes.ready is high.
// When the receiver holds result.ready low with a result waiting, the whole
// pipeline freezes and boxes.ready drops; nothing is dropped or repeated,
// and flow resumes the cycle result.ready returns.
// Results leave in the order pairs were accepted.
module swept_aabb_collision_time
    import swaabb_pkg::*;
#(
    parameter int DIV_STAGES = DIV_STAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    swaabb_stream_if.sink        boxes,
    swaabb_stream_if.source      result
);

    localparam int STEPS = Q_W / DIV_STAGES;

    typedef struct packed {
        logic                                    overlap;
        logic [1:0]                              dead;
        logic [LANES-1:0]                        use_t;
        logic [LANES-1:0]                        sat;
        logic [1:0][NUM_W-1:0]                   dv;
        logic [LANES-1:0][REM_W-1:0]             rem;
        logic [LANES-1:0][Q_W-1:0]               q;
    } div_t;

    logic      adv;
    logic      a_valid_reg;
    box_pair_t a_reg;
    logic      b_valid_reg;
    logic signed [1:0][DIFF_W-1:0] d1_reg, d2_reg, v_reg;
    logic      b_overlap_reg;

    logic      p_valid_reg [DIV_STAGES+1];
    div_t      p_reg       [DIV_STAGES+1];
    div_t      p_next      [DIV_STAGES+1];

    logic      out_valid_reg;
    contact_t  out_reg, out_next;

    assign adv          = !out_valid_reg || result.ready;
    assign boxes.ready  = adv;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // Stage A: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= boxes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= boxes.data;
        end
    end

    // Stage B: corner differences and relative velocity
    logic signed [1:0][DIFF_W-1:0] d1_next, d2_next, v_next;
    always_comb
    begin
        d1_next[0] = DIFF_W'(a_reg.b_min_x) - DIFF_W'(a_reg.a_max_x);
        d1_next[1] = DIFF_W'(a_reg.b_min_y) - DIFF_W'(a_reg.a_max_y);
        d2_next[0] = DIFF_W'(a_reg.b_max_x) - DIFF_W'(a_reg.a_min_x);
        d2_next[1] = DIFF_W'(a_reg.b_max_y) - DIFF_W'(a_reg.a_min_y);
        v_next[0]  = DIFF_W'(a_reg.vb_x) - DIFF_W'(a_reg.va_x);
        v_next[1]  = DIFF_W'(a_reg.vb_y) - DIFF_W'(a_reg.va_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            v_reg         <= v_next;
            b_overlap_reg <= !(a_reg.a_max_x < a_reg.b_min_x || a_reg.b_max_x < a_reg.a_min_x ||
                               a_reg.a_max_y < a_reg.b_min_y || a_reg.b_max_y < a_reg.a_min_y);
        end
    end

    // Stage C: per-axis slab decisions, magnitudes, saturation check
    function automatic logic [NUM_W-1:0] mag(input logic signed [DIFF_W-1:0] x);
        logic signed [DIFF_W-1:0] n;
        n = -x;
        return x[DIFF_W-1] ? NUM_W'(n) : NUM_W'(x);
    endfunction

    always_comb
    begin
        logic neg, pos, d1p, d1n, d2p, d2n;
        logic [NUM_W-1:0] ne, nx;
        p_next[0] = '0;
        p_next[0].overlap = b_overlap_reg;
        for (int ax = 0; ax < 2; ax++)
        begin
            neg = v_reg[ax][DIFF_W-1];
            pos = !neg && (v_reg[ax] != '0);
            d1p = !d1_reg[ax][DIFF_W-1] && (d1_reg[ax] != '0);
            d1n = d1_reg[ax][DIFF_W-1];
            d2p = !d2_reg[ax][DIFF_W-1] && (d2_reg[ax] != '0);
            d2n = d2_reg[ax][DIFF_W-1];
            p_next[0].dead[ax]       = neg ? d2n : (pos ? d1p : (d1p || d2n));
            p_next[0].use_t[2*ax]    = neg ? d1p : (pos ? d2n : 1'b0);
            p_next[0].use_t[2*ax+1]  = neg ? d2p : (pos ? d1n : 1'b0);
            ne = neg ? mag(d1_reg[ax]) : mag(d2_reg[ax]);
            nx = neg ? mag(d2_reg[ax]) : mag(d1_reg[ax]);
            p_next[0].dv[ax]         = mag(v_reg[ax]);
            p_next[0].rem[2*ax]      = REM_W'(ne);
            p_next[0].rem[2*ax+1]    = REM_W'(nx);
            // quotient would need more than 16 bits: time is past the frame
            p_next[0].sat[2*ax]      = REM_W'(ne) >= {mag(v_reg[ax]), 1'b0};
            p_next[0].sat[2*ax+1]    = REM_W'(nx) >= {mag(v_reg[ax]), 1'b0};
        end
    end

    // Divider stages: STEPS restoring steps per stage on all four lanes
    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_div
        always_comb
        begin
            logic [REM_W-1:0] r;
            logic [REM_W-1:0] dd;
            logic             bit_q;
            p_next[s] = p_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                r  = p_reg[s-1].rem[l];
                dd = REM_W'(p_reg[s-1].dv[l/2]);
                for (int k = 0; k < STEPS; k++)
                begin
                    bit_q = r >= dd;
                    if (bit_q)
                    begin
                        r = r - dd;
                    end
                    p_next[s].q[l] = {p_next[s].q[l][Q_W-2:0], bit_q};
                    r = {r[REM_W-2:0], 1'b0};
                end
                p_next[s].rem[l] = r;
            end
        end
    end

    for (genvar s = 0; s <= DIV_STAGES; s++)
    begin : g_pipe
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                p_valid_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                p_valid_reg[s] <= (s == 0) ? b_valid_reg : p_valid_reg[(s == 0) ? 0 : s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p_reg[s] <= p_next[s];
            end
        end
    end

    // Final: merge times, interval check, output register
    always_comb
    begin
        logic [T_W-1:0] t, tf, tl;
        div_t f;
        f  = p_reg[DIV_STAGES];
        tf = '0;
        tl = TIME_ONE;
        for (int l = 0; l < LANES; l++)
        begin
            t = f.sat[l] ? TIME_SAT : T_W'(f.q[l]);
            if (f.use_t[l])
            begin
                if (l % 2 == 0)
                begin
                    if (t > tf) tf = t;
                end
                else
                begin
                    if (t < tl) tl = t;
                end
            end
        end
        out_next = '0;
        if (f.overlap)
        begin
            out_next.hit = 1'b1;
        end
        else if (f.dead == 2'b00 && tf <= tl)
        begin
            out_next.hit     = 1'b1;
            out_next.t_first = tf[Q_W-1:0];
            out_next.t_last  = tl[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= p_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== test/swaabb_checker.sv =====
// Checker for the swept box contact-time block: predicts each result and compares.
// Depends on swaabb_pkg.
module swaabb_checker
    import swaabb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  logic   in_ready,
    input  box_pair_t in_data,
    input  logic   out_valid,
    input  logic   out_ready,
    input  contact_t out_data,
    output int     fail_count,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    contact_t contact_q[$];

    function automatic longint unsigned slab_time(longint num, longint vel);
        longint unsigned n;
        longint unsigned d;
        begin
            n = (num < 0) ? -num : num;
            d = (vel < 0) ? -vel : vel;
            if (d == 0)
                return 32768;
            return (n << 15) / d;
        end
    endfunction

    function automatic contact_t contact_of(box_pair_t p);
        longint amin[2], amax[2], bmin[2], bmax[2], v[2];
        longint unsigned tf, tl, t;
        contact_t r;
        begin
            amin[0] = p.a_min_x; amin[1] = p.a_min_y;
            amax[0] = p.a_max_x; amax[1] = p.a_max_y;
            bmin[0] = p.b_min_x; bmin[1] = p.b_min_y;
            bmax[0] = p.b_max_x; bmax[1] = p.b_max_y;
            v[0] = longint'(p.vb_x) - longint'(p.va_x);
            v[1] = longint'(p.vb_y) - longint'(p.va_y);
            r = '0;
            tf = 0;
            tl = 32768;
            if (!(amax[0] < bmin[0] || bmax[0] < amin[0] ||
                  amax[1] < bmin[1] || bmax[1] < amin[1]))
            begin
                r.hit = 1'b1;
                return r;
            end
            for (int i = 0; i < 2; i++)
            begin
                if (v[i] < 0)
                begin
                    if (bmax[i] < amin[i])
                        return r;
                    if (amax[i] < bmin[i])
                    begin
                        t = slab_time(bmin[i] - amax[i], v[i]);
                        if (t > tf) tf = t;
                    end
                    if (bmax[i] > amin[i])
                    begin
                        t = slab_time(bmax[i] - amin[i], v[i]);
                        if (t < tl) tl = t;
                    end
                end
                else if (v[i] > 0)
                begin
                    if (bmin[i] > amax[i])
                        return r;
                    if (bmax[i] < amin[i])
                    begin
                        t = slab_time(amin[i] - bmax[i], v[i]);
                        if (t > tf) tf = t;
                    end
                    if (amax[i] > bmin[i])
                    begin
                        t = slab_time(amax[i] - bmin[i], v[i]);
                        if (t < tl) tl = t;
                    end
                end
                else if (amax[i] < bmin[i] || bmax[i] < amin[i])
                    return r;
                if (tf > tl)
                    return r;
            end
            r.hit = 1'b1;
            r.t_first = tf[15:0];
            r.t_last = tl[15:0];
            return r;
        end
    endfunction

    assign pending = contact_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        contact_t want;
        if (!rst_n)
            fail_count <= 0;
        else
        begin
            if (in_valid && in_ready)
                contact_q.push_back(contact_of(in_data));
            if (out_valid && out_ready)
            begin
                if (contact_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = contact_q.pop_front();
                    if (want.hit !== out_data.hit || want.t_first !== out_data.t_first ||
                        want.t_last !== out_data.t_last)
                    begin
                        $display("%0t: mismatch expected hit=%0d tf=%0d tl=%0d actual hit=%0d tf=%0d tl=%0d",
                                 $time, want.hit, want.t_first, want.t_last,
                                 out_data.hit, out_data.t_first, out_data.t_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_top.sv =====
// Top of the swept box testbench: clock, reset, stimulus and verdict.
// Depends on swaabb_pkg, swaabb_stream_if, swaabb_checker and the block.
module tb_top;
    import swaabb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    swaabb_stream_if #(.payload_t(box_pair_t)) boxes ();
    swaabb_stream_if #(.payload_t(contact_t))  result ();

    swept_aabb_collision_time uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .boxes  (boxes.sink),
        .result (result.source)
    );

    swaabb_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (boxes.valid),
        .in_ready   (boxes.ready),
        .in_data    (boxes.data),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_data   (result.data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [23:0] rand_coord(int mode);
        begin
            case (mode)
                0: return 24'($urandom);
                1: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
                2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                default: return $signed(24'($urandom_range(0, 255))) - 24'sd128;
            endcase
        end
    endfunction

    // Mostly small, near-touching scenes so hits, misses and times all show up.
    function automatic box_pair_t rand_pair();
        box_pair_t p;
        int m;
        begin
            m = $urandom_range(0, 9);
            if (m == 0)
                p = {24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom)};
            else
            begin
                m = (m < 3) ? 1 : (m == 3 ? 2 : 3);
                p.a_min_x = rand_coord(m); p.a_max_x = p.a_min_x + rand_coord(3) + 24'sd128;
                p.a_min_y = rand_coord(m); p.a_max_y = p.a_min_y + rand_coord(3) + 24'sd128;
                p.b_min_x = rand_coord(m); p.b_max_x = p.b_min_x + rand_coord(3) + 24'sd128;
                p.b_min_y = rand_coord(m); p.b_max_y = p.b_min_y + rand_coord(3) + 24'sd128;
                p.va_x = ($urandom_range(0, 5) == 0) ? 24'sd0 : rand_coord(m);
                p.va_y = ($urandom_range(0, 5) == 0) ? 24'sd0 : rand_coord(m);
                p.vb_x = ($urandom_range(0, 5) == 0) ? p.va_x : rand_coord(m);
                p.vb_y = ($urandom_range(0, 5) == 0) ? p.va_y : rand_coord(m);
            end
            return p;
        end
    endfunction

    function automatic box_pair_t mk(int ax0, int ay0, int ax1, int ay1, int bx0, int by0,
                                     int bx1, int by1, int vax, int vay, int vbx, int vby);
        box_pair_t p;
        begin
            p.a_min_x = 24'(ax0); p.a_min_y = 24'(ay0);
            p.a_max_x = 24'(ax1); p.a_max_y = 24'(ay1);
            p.b_min_x = 24'(bx0); p.b_min_y = 24'(by0);
            p.b_max_x = 24'(bx1); p.b_max_y = 24'(by1);
            p.va_x = 24'(vax); p.va_y = 24'(vay); p.vb_x = 24'(vbx); p.vb_y = 24'(vby);
            return p;
        end
    endfunction

    // valid drops only when a gap follows, so back-to-back beats keep it high
    task automatic send(box_pair_t p);
        int gap;
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                boxes.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            boxes.valid <= 1'b1;
            boxes.data <= p;
            @(posedge clk);
            while (!boxes.ready)
                @(posedge clk);
        end
    endtask

    // Receiver stalls drawn per result beat.
    initial
    begin
        int stall;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((boxes.valid && boxes.ready) || (result.valid && result.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        boxes.valid <= 1'b0;
        boxes.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // overlap, touching edge, all extremes
        send(mk(0, 0, 256, 256, 128, 128, 512, 512, 0, 0, 0, 0));
        send(mk(0, 0, 256, 256, 256, 256, 512, 512, 0, 0, 0, 0));
        send(mk(-8388608, -8388608, 8388607, 8388607, -8388608, -8388608,
                8388607, 8388607, 8388607, 8388607, -8388608, -8388608));
        // approach along x, along y, both
        send(mk(0, 0, 256, 256, 1024, 0, 1280, 256, 0, 0, -2048, 0));
        send(mk(0, 0, 256, 256, 0, 1024, 256, 1280, 0, 1536, 0, 0));
        send(mk(0, 0, 256, 256, 1024, 1024, 1280, 1280, 512, 512, -512, -512));
        // moving apart
        send(mk(0, 0, 256, 256, 1024, 0, 1280, 256, 0, 0, 100, 0));
        send(mk(1024, 0, 1280, 256, 0, 0, 256, 256, 0, 0, -100, 0));
        // zero relative velocity with gap
        send(mk(0, 0, 256, 256, 1024, 0, 1280, 256, 50, 0, 50, 0));
        send(mk(0, 0, 256, 256, 0, 1024, 256, 1280, 7, 7, 7, 7));
        // too slow, and empty interval across axes
        send(mk(0, 0, 256, 256, 4096, 0, 4352, 256, 0, 0, -512, 0));
        send(mk(0, 0, 256, 256, 1024, 4096, 1280, 4352, 0, 0, -1024, -100));
        // inverted boxes
        send(mk(256, 256, 0, 0, 128, 128, 64, 64, 0, 0, 0, 0));
        send(mk(512, 0, 0, 256, 1024, 0, 768, 256, 0, 0, -300, 0));
        // extreme relative speed
        send(mk(-8388608, 0, -8388607, 1, 8388606, 0, 8388607, 1,
                8388607, 0, -8388608, 0));
        send(mk(8388606, 0, 8388607, 1, -8388608, 0, -8388607, 1,
                -8388608, 0, 8388607, 0));
        repeat (1650) send(rand_pair());
        boxes.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
